>>> rtl/dmar_pkg.sv
// Package for the max/argmax reduction unit: depth limits, constants, float compare.
// Used by dmar_acc and dimwise_max_argmax_reduce_unit. No dependencies.
package dmar_pkg;
  localparam int unsigned ColumnDepth = 1024;
  localparam int unsigned ReduceMax   = 65535;
  localparam logic [31:0] NegFltMax   = 32'hFF7F_FFFF;

  typedef enum logic [0:0] {
    REG_REDUCE_LENGTH = 1'b0,
    REG_COLUMN_COUNT  = 1'b1
  } reg_idx_e;

  function automatic logic f32_is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] f32_key(input logic [31:0] b);
    logic [31:0] k;
    if (b[30:0] == 31'd0) k = 32'h8000_0000;
    else if (b[31])       k = ~b;
    else                  k = b | 32'h8000_0000;
    return k;
  endfunction

  function automatic logic f32_gt(input logic [31:0] a, input logic [31:0] b);
    return !f32_is_nan(a) && !f32_is_nan(b) && (f32_key(a) > f32_key(b));
  endfunction
endpackage

>>> rtl/dmar_acc.sv
// Accumulator: per-column max/index memory with read-modify-write pipeline.
// Depends on dmar_pkg.
module dmar_acc #(
  parameter int unsigned ColumnDepth = dmar_pkg::ColumnDepth,
  parameter int unsigned RowW        = 16,
  parameter int unsigned ColW        = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic [31:0]     in_elem_i,
  input  logic [RowW-1:0] in_row_i,
  input  logic [ColW-1:0] in_col_i,
  input  logic            in_first_i,
  input  logic            in_last_row_i,
  input  logic            in_last_col_i,
  output logic            res_valid_o,
  output logic [31:0]     res_max_o,
  output logic [RowW-1:0] res_best_o,
  output logic [ColW-1:0] res_col_o,
  output logic            res_end_o
);
  localparam int unsigned AW = (ColumnDepth > 1) ? $clog2(ColumnDepth) : 1;
  logic [31:0]     mem_max_q  [ColumnDepth];
  logic [RowW-1:0] mem_best_q [ColumnDepth];
  logic [31:0]     rd_max_q;
  logic [RowW-1:0] rd_best_q;
  logic            s1_valid_q, s1_first_q, s1_lrow_q, s1_lcol_q;
  logic [31:0]     s1_elem_q;
  logic [RowW-1:0] s1_row_q;
  logic [ColW-1:0] s1_col_q;
  logic            wb_valid_q;
  logic [ColW-1:0] wb_col_q;
  logic [31:0]     wb_max_q;
  logic [RowW-1:0] wb_best_q;
  logic [31:0]     bnd_in, new_max;
  logic [RowW-1:0] best_in, new_best;
  logic            adv;
  logic [AW-1:0]   rd_addr, wr_addr;

  assign adv     = !in_stall_i;
  assign rd_addr = AW'(in_col_i);
  assign wr_addr = AW'(s1_col_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_max_q  <= mem_max_q[rd_addr];
      rd_best_q <= mem_best_q[rd_addr];
    end
    if (adv && s1_valid_q && !s1_lrow_q) begin
      mem_max_q[wr_addr]  <= new_max;
      mem_best_q[wr_addr] <= new_best;
    end
  end

  always_comb begin
    if (s1_first_q) begin
      bnd_in = dmar_pkg::NegFltMax;
      best_in = '0;
    end else if (wb_valid_q && wb_col_q == s1_col_q) begin
      bnd_in = wb_max_q;
      best_in = wb_best_q;
    end else begin
      bnd_in = rd_max_q;
      best_in = rd_best_q;
    end
    if (dmar_pkg::f32_gt(s1_elem_q, bnd_in)) begin
      new_max = s1_elem_q;
      new_best = s1_row_q;
    end else begin
      new_max = bnd_in;
      new_best = best_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      wb_valid_q  <= 1'b0;
      res_valid_o <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      wb_valid_q  <= s1_valid_q && !s1_lrow_q;
      res_valid_o <= s1_valid_q && s1_lrow_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_elem_q  <= in_elem_i;
      s1_row_q   <= in_row_i;
      s1_col_q   <= in_col_i;
      s1_first_q <= in_first_i;
      s1_lrow_q  <= in_last_row_i;
      s1_lcol_q  <= in_last_col_i;
      wb_col_q   <= s1_col_q;
      wb_max_q   <= new_max;
      wb_best_q  <= new_best;
      res_max_o  <= new_max;
      res_best_o <= new_best;
      res_col_o  <= s1_col_q;
      res_end_o  <= s1_lcol_q;
    end
  end

  // a pending result holds while stalled; a stage-1 item either writes back or emits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && in_stall_i |=> res_valid_o) else $error("result dropped on stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_valid_o && wb_valid_q)) else $error("result and writeback overlap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_first_q |-> s1_row_q == '0) else $error("first row not zero");
endmodule

>>> rtl/dimwise_max_argmax_reduce_unit.sv
// Top level of the strided max/argmax reduction unit: position counters,
// config registers and output handshake. Depends on dmar_pkg, dmar_acc.
//
// Usage: binary32 elements enter on s_axis (tdata = element_bits) in row-major
// order (outer, reduced row, inner column). For each column a running maximum
// and first index are kept in an on-chip memory (read, compare, write back,
// with forwarding for back-to-back hits on a column).
// On the last reduced row every element yields one request on m_axis:
// tdata = max_bits, best_index, column from bit 0 up; tlast = group_end.
// Throughput: one element per cycle while the receiver does not stall.
// Pipeline: two register stages, stage 1 and the output register.
// The pipeline advances only when the output register is empty or taken;
// when the receiver stalls with a result pending, s_axis_tready drops.
// Config writes (cfg index 0 reduce_length, 1 column_count) restart the
// stream; the user must make them only while idle, which the block itself
// does not enforce. Reset zeroes the counters, sets both registers to 1;
// the memory needs no clearing since row zero never reads it.
module dimwise_max_argmax_reduce_unit #(
  parameter int unsigned COLUMN_DEPTH = dmar_pkg::ColumnDepth,
  parameter int unsigned REDUCE_MAX   = dmar_pkg::ReduceMax
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // element_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // max_bits, best_index, column, zeros
  output logic        m_axis_tlast,   // group_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned RowW = 16;
  localparam int unsigned ColW = (COLUMN_DEPTH > 1024) ? 11 : 10;
  localparam int unsigned CfgW = $clog2(COLUMN_DEPTH + 1) > 11 ? $clog2(COLUMN_DEPTH + 1) : 11;

  logic [15:0]     rlen_q;
  logic [10:0]     ccnt_q;
  logic [19:0]     rows_eff;
  logic [CfgW-1:0] cols_eff;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic            stall, acc, last_row, last_col;
  logic [31:0]     r_max;
  logic [RowW-1:0] r_best;
  logic [ColW-1:0] r_col;
  logic            r_end;

  always_comb begin
    rows_eff = (rlen_q == 16'd0) ? 20'd1 : 20'(rlen_q);
    if (rows_eff > 20'(REDUCE_MAX)) rows_eff = 20'(REDUCE_MAX);
    cols_eff = (ccnt_q == 11'd0) ? CfgW'(1) : CfgW'(ccnt_q);
    if (cols_eff > CfgW'(COLUMN_DEPTH)) cols_eff = CfgW'(COLUMN_DEPTH);
  end

  assign stall         = m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = !stall;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign last_row      = (20'(row_q) + 20'd1) == rows_eff;
  assign last_col      = (CfgW'(col_q) + CfgW'(1)) == cols_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rlen_q <= 16'd1;
      ccnt_q <= 11'd1;
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_valid_i) begin
      case (dmar_pkg::reg_idx_e'(cfg_index_i))
        dmar_pkg::REG_REDUCE_LENGTH: rlen_q <= cfg_data_i;
        dmar_pkg::REG_COLUMN_COUNT:  ccnt_q <= cfg_data_i[10:0];
        default: ;
      endcase
      row_q <= '0;
      col_q <= '0;
    end else if (acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  dmar_acc #(.ColumnDepth(COLUMN_DEPTH), .RowW(RowW), .ColW(ColW)) u_acc (
    .clk_i, .rst_ni,
    .in_valid_i(acc), .in_stall_i(stall), .in_elem_i(s_axis_tdata),
    .in_row_i(row_q), .in_col_i(col_q), .in_first_i(row_q == '0),
    .in_last_row_i(last_row), .in_last_col_i(last_col),
    .res_valid_o(m_axis_tvalid), .res_max_o(r_max), .res_best_o(r_best),
    .res_col_o(r_col), .res_end_o(r_end)
  );

  assign m_axis_tdata = {6'd0, r_col[9:0], r_best, r_max};
  assign m_axis_tlast = r_end;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("payload moved");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CfgW'(col_q) < cols_eff || $past(cfg_valid_i)) else $error("column out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_col && last_row |=> row_q == '0 && col_q == '0) else $error("wrap failed");
endmodule
